/* hw/rtl/clws_pkg.sv */
// Package for the character LCD write sequencer: types, constants and microcode ROM.
`default_nettype none

package clws_pkg;

	// Sizes
	localparam int MAX_DIGITS   = 10;
	localparam int LINE_COLUMNS = 16;
	localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W        = $clog2(MAX_DIGITS);
	localparam int IN_DATA_W    = 48;
	localparam int PC_W         = 4;

	// Character and command constants
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_MINUS  = 8'h2D;
	localparam logic [7:0] CMD_LINE1  = 8'h80;
	localparam logic [7:0] CMD_LINE2  = 8'hC0;
	localparam logic [7:0] LINE2_OFFS = 8'h40;

	// Reciprocal of ten: q = (x * RECIP10) >> 35 is exact for 32-bit x
	localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
	localparam int          RECIP_SH = 35;

	// Operation codes on tuser of the input channel
	typedef enum logic [1:0] {
		OP_CMD    = 2'd0,
		OP_DATA   = 2'd1,
		OP_CURSOR = 2'd2,
		OP_NUMBER = 2'd3
	} opcode_t;

	// Row codes that move the cursor
	localparam logic [1:0] ROW_FIRST  = 2'd1;
	localparam logic [1:0] ROW_SECOND = 2'd2;

	// Micro-operations
	typedef enum logic [2:0] {
		U_WAIT = 3'd0,   // take the next input item
		U_NOP  = 3'd1,   // test and branch only
		U_SEND = 3'd2,   // hand one byte to the strobe emitter
		U_MUL  = 3'd3,   // quotient by ten
		U_DIV  = 3'd4    // store remainder digit, keep quotient
	} uop_t;

	// Branch conditions
	typedef enum logic [2:0] {
		C_NEVER    = 3'd0,
		C_ALWAYS   = 3'd1,
		C_IS_NUM   = 3'd2,
		C_NO_BYTE  = 3'd3,
		C_MAG_ZERO = 3'd4,
		C_NOT_NEG  = 3'd5,
		C_MORE     = 3'd6,   // quotient left and store not full
		C_CNT_MORE = 3'd7    // more than one digit left to send
	} cond_t;

	// Byte source for a send
	typedef enum logic [1:0] {
		S_BYTE  = 2'd0,
		S_MINUS = 2'd1,
		S_ZERO  = 2'd2,
		S_DIGIT = 2'd3
	} src_t;

	// Last flag for a send
	typedef enum logic [1:0] {
		L_NO    = 2'd0,
		L_YES   = 2'd1,
		L_DIGIT = 2'd2
	} last_sel_t;

	// Control word
	typedef struct packed {
		uop_t            uop;
		cond_t           cond;
		src_t            src;
		last_sel_t       lsel;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// Byte handed to the strobe emitter
	typedef struct packed {
		logic       valid;
		logic       rs;
		logic       last;
		logic [7:0] data;
	} emit_req_t;

	// Microcode ROM
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{uop: U_WAIT, cond: C_NEVER, src: S_BYTE, lsel: L_NO, target: '0};
		case (pc)
			4'd0:  w = '{U_WAIT, C_NEVER,    S_BYTE,  L_NO,    4'd0};
			4'd1:  w = '{U_NOP,  C_IS_NUM,   S_BYTE,  L_NO,    4'd4};
			4'd2:  w = '{U_NOP,  C_NO_BYTE,  S_BYTE,  L_NO,    4'd0};
			4'd3:  w = '{U_SEND, C_ALWAYS,   S_BYTE,  L_YES,   4'd0};
			4'd4:  w = '{U_NOP,  C_MAG_ZERO, S_BYTE,  L_NO,    4'd11};
			4'd5:  w = '{U_NOP,  C_NOT_NEG,  S_BYTE,  L_NO,    4'd7};
			4'd6:  w = '{U_SEND, C_NEVER,    S_MINUS, L_NO,    4'd0};
			4'd7:  w = '{U_MUL,  C_NEVER,    S_BYTE,  L_NO,    4'd0};
			4'd8:  w = '{U_DIV,  C_MORE,     S_BYTE,  L_NO,    4'd7};
			4'd9:  w = '{U_SEND, C_CNT_MORE, S_DIGIT, L_DIGIT, 4'd9};
			4'd10: w = '{U_NOP,  C_ALWAYS,   S_BYTE,  L_NO,    4'd0};
			4'd11: w = '{U_SEND, C_ALWAYS,   S_ZERO,  L_YES,   4'd0};
			default: w = '{U_NOP, C_ALWAYS,  S_BYTE,  L_NO,    4'd0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/clws_emit.sv */
// Strobe emitter: turns one byte into one or two bus transfers with an output register.
`default_nettype none

module clws_emit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               bus_mode,   // 1 four-bit bus
	input  wire clws_pkg::emit_req_t req,
	output logic                    req_ready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,    // [7:0] bus_value
	output logic                    m_tuser,    // [0] register_select
	output logic                    m_tlast
);

	logic       busy_q;
	logic       phase_q;
	logic       rs_q;
	logic       last_q;
	logic [7:0] byte_q;
	logic       xfer;
	logic       final_strobe;

	assign final_strobe = !bus_mode || phase_q;
	assign xfer         = m_tvalid && m_tready;
	assign req_ready    = !busy_q || (xfer && final_strobe);

	// Output view of the held byte
	assign m_tvalid = busy_q;
	assign m_tuser  = rs_q;
	assign m_tlast  = last_q && final_strobe;
	always_comb begin
		if (!bus_mode) begin
			m_tdata = byte_q;
		end else if (phase_q) begin
			m_tdata = {4'b0000, byte_q[3:0]};
		end else begin
			m_tdata = {4'b0000, byte_q[7:4]};
		end
	end

	// Control: busy flag and nibble phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (req.valid && req_ready) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (xfer) begin
			if (final_strobe) begin
				busy_q  <= 1'b0;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			byte_q <= req.data;
			rs_q   <= req.rs;
			last_q <= req.last;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/char_lcd_write_sequencer.sv */
// Top level of the character LCD write sequencer: microcoded control and datapath.
//
// Usage: each transfer on the s_ channel is one operation (tuser = opcode): command
// byte, data byte, cursor move, or a signed 32-bit number printed in decimal. Each
// byte it produces leaves on the m_ channel as enable strobes: two nibble transfers
// (high first, in bits 3..0) on the four-bit bus, one on the eight-bit bus. tuser
// carries RS, tlast marks the final strobe of the operation. A cursor move out of
// range produces no transfer. cfg_ writes set the bus mode; write only while idle.
// Sequencing: a step counter walks a 12-word microcode ROM, one word per cycle
// while it is not stalled waiting for input or for the emitter. A byte or cursor
// move runs through its tests and, when in range, a single hand-over. A number
// runs through its tests (and the '-' hand-over when negative), a reciprocal
// multiply and a remainder step per digit, one hand-over per digit and a closing step.
// The emitter holds one byte, so control runs ahead by one byte and the next item
// is taken while the last strobes still wait.
// A stalled sink holds its transfer and stops control at the next send.
// Reset returns control to the wait step, empties the emitter and selects the
// four-bit bus.
`default_nettype none

module char_lcd_write_sequencer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [clws_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] byte_value,
	                                                         // [39:8] number,
	                                                         // [41:40] row,
	                                                         // [46:42] column
	input  wire logic [1:0]                        s_tuser,  // [1:0] opcode
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [7:0]                             m_tdata,  // [7:0] bus_value
	output logic                                   m_tuser,  // [0] register_select
	output logic                                   m_tlast,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic                              cfg_data  // bus_mode
);

	// Input fields
	logic [7:0]  in_byte;
	logic [31:0] in_number;
	logic [1:0]  in_row;
	logic [4:0]  in_column;
	assign in_byte   = s_tdata[7:0];
	assign in_number = s_tdata[39:8];
	assign in_row    = s_tdata[41:40];
	assign in_column = s_tdata[46:42];

	// Registers
	logic [clws_pkg::PC_W-1:0]  pc_q;
	logic                       bus_mode_q;
	logic                       is_num_q;
	logic                       byte_ok_q;
	logic                       rs_q;
	logic [7:0]                 byte_q;
	logic                       neg_q;
	logic [31:0]                mag_q;
	logic [31-clws_pkg::RECIP_SH+32:0] quot_q;
	logic [clws_pkg::CNT_W-1:0] cnt_q;
	logic [3:0]                 digit_q [clws_pkg::MAX_DIGITS];

	clws_pkg::ctrl_t     ctrl;
	clws_pkg::emit_req_t req;
	logic                emit_ready;
	logic                accept;
	logic                stall;
	logic                cond_hit;

	assign ctrl     = clws_pkg::ucode(pc_q);
	assign s_tready = (ctrl.uop == clws_pkg::U_WAIT);
	assign accept   = s_tvalid && s_tready;
	assign stall    = (ctrl.uop == clws_pkg::U_WAIT && !s_tvalid) ||
	                  (ctrl.uop == clws_pkg::U_SEND && !emit_ready);

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			bus_mode_q <= cfg_data;
		end
	end

	// Decode of the accepted item
	logic [7:0]  col_byte;
	logic        col_ok;
	logic [7:0]  dec_byte;
	logic        dec_ok;
	logic [31:0] dec_mag;
	assign col_byte = {3'b000, in_column};
	assign col_ok   = {1'b0, col_byte} < 9'(clws_pkg::LINE_COLUMNS);
	assign dec_mag  = in_number[31] ? (32'd0 - in_number) : in_number;
	always_comb begin
		dec_byte = in_byte;
		dec_ok   = 1'b1;
		case (clws_pkg::opcode_t'(s_tuser))
			clws_pkg::OP_CMD, clws_pkg::OP_DATA: begin
				dec_byte = in_byte;
				dec_ok   = 1'b1;
			end
			clws_pkg::OP_CURSOR: begin
				if (in_row == clws_pkg::ROW_FIRST) begin
					dec_byte = col_byte | clws_pkg::CMD_LINE1;
					dec_ok   = col_ok;
				end else if (in_row == clws_pkg::ROW_SECOND) begin
					dec_byte = (col_byte + clws_pkg::LINE2_OFFS) | clws_pkg::CMD_LINE2;
					dec_ok   = col_ok;
				end else begin
					dec_ok   = 1'b0;
				end
			end
			default: begin
				dec_ok = 1'b0;
			end
		endcase
	end

	// Division by ten through the reciprocal
	logic [63:0] prod;
	logic [31:0] quot_x10;
	logic [31:0] rem_full;
	assign prod     = 64'(mag_q) * 64'(clws_pkg::RECIP10);
	assign quot_x10 = 32'({quot_q, 3'b000}) + 32'({quot_q, 1'b0});
	assign rem_full = mag_q - quot_x10;

	// Digit read address
	logic [clws_pkg::CNT_W-1:0] rd_cnt;
	logic [3:0]                 rd_digit;
	assign rd_cnt   = cnt_q - 1'b1;
	assign rd_digit = digit_q[rd_cnt[clws_pkg::IDX_W-1:0]];

	// Branch conditions
	always_comb begin
		case (ctrl.cond)
			clws_pkg::C_NEVER:    cond_hit = 1'b0;
			clws_pkg::C_ALWAYS:   cond_hit = 1'b1;
			clws_pkg::C_IS_NUM:   cond_hit = is_num_q;
			clws_pkg::C_NO_BYTE:  cond_hit = !byte_ok_q;
			clws_pkg::C_MAG_ZERO: cond_hit = (mag_q == 32'd0);
			clws_pkg::C_NOT_NEG:  cond_hit = !neg_q;
			clws_pkg::C_MORE:     cond_hit = (quot_q != '0) &&
			                          ((cnt_q + 1'b1) <
			                           clws_pkg::CNT_W'(clws_pkg::MAX_DIGITS));
			clws_pkg::C_CNT_MORE: cond_hit = (cnt_q != clws_pkg::CNT_W'(1));
			default:              cond_hit = 1'b0;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (!stall) begin
			pc_q <= cond_hit ? ctrl.target : (pc_q + 1'b1);
		end
	end

	// Digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (ctrl.uop == clws_pkg::U_DIV) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (ctrl.uop == clws_pkg::U_SEND && ctrl.src == clws_pkg::S_DIGIT &&
		             emit_ready) begin
			cnt_q <= rd_cnt;
		end
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			is_num_q  <= (s_tuser == clws_pkg::OP_NUMBER);
			byte_ok_q <= dec_ok;
			rs_q      <= (s_tuser == clws_pkg::OP_DATA);
			byte_q    <= dec_byte;
			neg_q     <= in_number[31];
			mag_q     <= dec_mag;
		end else if (ctrl.uop == clws_pkg::U_DIV) begin
			mag_q <= 32'(quot_q);
		end
		if (ctrl.uop == clws_pkg::U_MUL) begin
			quot_q <= prod[63:clws_pkg::RECIP_SH];
		end
	end

	// Digit store
	always_ff @(posedge clk) begin
		if (ctrl.uop == clws_pkg::U_DIV) begin
			digit_q[cnt_q[clws_pkg::IDX_W-1:0]] <= rem_full[3:0];
		end
	end

	// Byte request to the emitter
	always_comb begin
		req.valid = (ctrl.uop == clws_pkg::U_SEND);
		req.rs    = 1'b1;
		req.data  = byte_q;
		case (ctrl.src)
			clws_pkg::S_BYTE: begin
				req.data = byte_q;
				req.rs   = rs_q;
			end
			clws_pkg::S_MINUS: req.data = clws_pkg::CHR_MINUS;
			clws_pkg::S_ZERO:  req.data = clws_pkg::CHR_ZERO;
			clws_pkg::S_DIGIT: req.data = clws_pkg::CHR_ZERO | {4'b0000, rd_digit};
			default:           req.data = byte_q;
		endcase
		case (ctrl.lsel)
			clws_pkg::L_NO:    req.last = 1'b0;
			clws_pkg::L_YES:   req.last = 1'b1;
			clws_pkg::L_DIGIT: req.last = (cnt_q == clws_pkg::CNT_W'(1));
			default:           req.last = 1'b0;
		endcase
	end

	clws_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.bus_mode  (bus_mode_q),
		.req       (req),
		.req_ready (emit_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the character LCD write sequencer: plan-driven stimulus and strobe checker.
module testbench;
	import clws_pkg::*;

	localparam int   SETTLE_CYCLES = 64;
	localparam int   HOLD_CYCLES   = 400;
	localparam int   CYCLE_LIMIT   = 400000;
	localparam int   IDLE_NONE     = 0;
	localparam int   IDLE_HEAVY    = 51;
	localparam int   IDLE_LIGHT    = 8;
	localparam logic BUS_EIGHT     = 1'b0;
	localparam logic BUS_FOUR      = 1'b1;
	localparam logic RS_CMD        = 1'b0;
	localparam logic RS_DATA       = 1'b1;
	localparam logic [1:0] ROW_ZERO  = 2'd0;
	localparam logic [1:0] ROW_THREE = 2'd3;

	typedef enum logic [2:0] {
		P_OP,
		P_BUS_MODE,
		P_DRAIN,
		P_IDLING,
		P_HOLD
	} plan_kind_t;

	typedef struct {
		plan_kind_t  kind;
		opcode_t     opcode;
		logic [7:0]  byte_value;
		logic [31:0] number;
		logic [1:0]  row;
		logic [4:0]  column;
		logic        mode;
		int          send_idle;
		int          recv_stall;
	} plan_step_t;

	typedef struct packed {
		logic       rs;
		logic [7:0] bus;
		logic       last;
	} strobe_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata   = '0;  // [7:0] byte_value, [39:8] number,
	                                       // [41:40] row, [46:42] column
	logic [1:0]           s_tuser   = '0;  // [1:0] opcode
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;         // [7:0] bus_value
	logic                 m_tuser;         // [0] register_select
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data  = 1'b0;  // bus_mode

	plan_step_t op_plan[$];
	plan_step_t cur_op;
	strobe_t    strobes_due[$];
	logic       bus_four      = BUS_FOUR;
	int         send_idle     = 0;
	int         recv_stall    = 0;
	int         hold_requests = 0;
	int         holds_served  = 0;
	int         hold_left     = 0;
	int         quiet_cycles  = 0;
	int         mismatches    = 0;
	int         cycles        = 0;

	char_lcd_write_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One byte onto the display bus: two nibbles high first, or one strobe
	task automatic push_lcd_byte(ref strobe_t seq[$], input logic rs, input logic [7:0] b);
		if (bus_four) begin
			seq.push_back('{rs, {4'h0, b[7:4]}, 1'b0});
			seq.push_back('{rs, {4'h0, b[3:0]}, 1'b0});
		end else begin
			seq.push_back('{rs, b, 1'b0});
		end
	endtask

	// Strobes one operation produces under the current bus mode
	task automatic predict_strobes(input plan_step_t op);
		strobe_t     seq[$];
		strobe_t     tail;
		logic [31:0] mag;
		logic [3:0]  digits[MAX_DIGITS];
		int          count;
		count = 0;
		case (op.opcode)
			OP_CMD:  push_lcd_byte(seq, RS_CMD, op.byte_value);
			OP_DATA: push_lcd_byte(seq, RS_DATA, op.byte_value);
			OP_CURSOR: begin
				// out-of-range row or column sends nothing
				if (op.column < LINE_COLUMNS) begin
					if (op.row == ROW_FIRST)
						push_lcd_byte(seq, RS_CMD, {3'b000, op.column} | CMD_LINE1);
					else if (op.row == ROW_SECOND)
						push_lcd_byte(seq, RS_CMD, ({3'b000, op.column} + LINE2_OFFS) | CMD_LINE2);
				end
			end
			default: begin
				// magnitude taken unsigned, so the most negative value wraps onto itself
				mag = op.number[31] ? 32'd0 - op.number : op.number;
				if (mag == 32'd0) begin
					push_lcd_byte(seq, RS_DATA, CHR_ZERO);
				end else begin
					if (op.number[31])
						push_lcd_byte(seq, RS_DATA, CHR_MINUS);
					while (mag != 32'd0 && count < MAX_DIGITS) begin
						digits[count] = 4'(mag % 32'd10);
						mag = mag / 32'd10;
						count++;
					end
					while (count > 0) begin
						count--;
						push_lcd_byte(seq, RS_DATA, CHR_ZERO + {4'h0, digits[count]});
					end
				end
			end
		endcase
		if (seq.size() != 0) begin
			tail = seq.pop_back();
			tail.last = 1'b1;
			seq.push_back(tail);
		end
		foreach (seq[i])
			strobes_due.push_back(seq[i]);
	endtask

	// Plan building
	function automatic plan_step_t plan_entry(plan_kind_t kind);
		plan_step_t e;
		e.kind       = kind;
		e.opcode     = OP_CMD;
		e.byte_value = '0;
		e.number     = '0;
		e.row        = '0;
		e.column     = '0;
		e.mode       = BUS_FOUR;
		e.send_idle  = 0;
		e.recv_stall = 0;
		return e;
	endfunction

	function automatic void add_op(opcode_t opc, logic [7:0] b, logic [31:0] num,
		logic [1:0] r, logic [4:0] c);
		plan_step_t e;
		e            = plan_entry(P_OP);
		e.opcode     = opc;
		e.byte_value = b;
		e.number     = num;
		e.row        = r;
		e.column     = c;
		op_plan.push_back(e);
	endfunction

	function automatic void add_bus_mode(logic m);
		plan_step_t e;
		e      = plan_entry(P_BUS_MODE);
		e.mode = m;
		op_plan.push_back(e);
	endfunction

	function automatic void add_idling(int si, int rs);
		plan_step_t e;
		e            = plan_entry(P_IDLING);
		e.send_idle  = si;
		e.recv_stall = rs;
		op_plan.push_back(e);
	endfunction

	// Mostly in-range cursor columns; numbers mix full range, small values and extremes
	function automatic void add_random_ops(int n);
		logic [31:0] num;
		logic [4:0]  col;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(4))
				0, 1:    num = $urandom;
				2:       num = $urandom_range(99);
				3:       num = 32'd0 - $urandom_range(99999);
				default: begin
					case ($urandom_range(3))
						0:       num = 32'h0000_0000;
						1:       num = 32'h8000_0000;
						2:       num = 32'h7FFF_FFFF;
						default: num = 32'hFFFF_FFFF;
					endcase
				end
			endcase
			col = ($urandom_range(3) == 0) ? 5'($urandom_range(31, 16)) : 5'($urandom_range(15));
			add_op(opcode_t'($urandom_range(3)), 8'($urandom_range(255)), num,
				2'($urandom_range(3)), col);
		end
	endfunction

	// Stimulus driver: takes plan steps one at a time
	always @(posedge clk) begin : drive
		logic       next_valid;
		logic       next_cfg;
		plan_step_t step;
		next_valid = s_tvalid;
		next_cfg   = cfg_valid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_strobes(cur_op);
				next_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				bus_four = cfg_data;
				next_cfg = 1'b0;
			end
			// cycles with nothing in flight on any channel
			if (s_tvalid || cfg_valid || m_tvalid || strobes_due.size() != 0)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (!next_valid && !next_cfg && op_plan.size() != 0) begin
				step = op_plan[0];
				case (step.kind)
					P_OP: begin
						if ($urandom_range(99) >= send_idle) begin
							cur_op = step;
							void'(op_plan.pop_front());
							s_tdata    <= {1'b0, step.column, step.row, step.number, step.byte_value};
							s_tuser    <= step.opcode;
							next_valid = 1'b1;
						end
					end
					P_BUS_MODE: begin
						// block must be idle, including items that sent nothing
						if (quiet_cycles >= SETTLE_CYCLES) begin
							void'(op_plan.pop_front());
							cfg_data <= step.mode;
							next_cfg = 1'b1;
						end
					end
					P_DRAIN: begin
						if (strobes_due.size() == 0)
							void'(op_plan.pop_front());
					end
					P_IDLING: begin
						send_idle  = step.send_idle;
						recv_stall = step.recv_stall;
						void'(op_plan.pop_front());
					end
					default: begin
						hold_requests++;
						void'(op_plan.pop_front());
					end
				endcase
			end
		end
		s_tvalid  <= next_valid;
		cfg_valid <= next_cfg;
	end

	// Sink ready: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left    = HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Strobe checker against the oldest expectation
	always @(posedge clk) begin : check
		strobe_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (strobes_due.size() == 0) begin
				$error("unexpected strobe: register_select %0b bus_value %02h last %0b",
					m_tuser, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = strobes_due.pop_front();
				if (m_tuser !== want.rs) begin
					$error("register_select: expected %0b, actual %0b", want.rs, m_tuser);
					mismatches++;
				end
				if (m_tdata !== want.bus) begin
					$error("bus_value: expected %02h, actual %02h", want.bus, m_tdata);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		// directed: four-bit bus after reset
		add_op(OP_CMD, 8'h00, 32'd0, ROW_ZERO, 5'd0);
		add_op(OP_CMD, 8'hFF, 32'd0, ROW_ZERO, 5'd0);
		add_op(OP_DATA, 8'hA5, 32'd0, ROW_ZERO, 5'd0);
		add_op(OP_DATA, 8'h5A, 32'd0, ROW_ZERO, 5'd0);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_FIRST, 5'd0);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_FIRST, 5'd15);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_SECOND, 5'd0);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_SECOND, 5'd15);
		// cursor out of range: bad row, then bad column
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_ZERO, 5'd5);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_THREE, 5'd3);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_FIRST, 5'd16);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_SECOND, 5'd31);
		add_op(OP_NUMBER, 8'h00, 32'd0, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'hFFFF_FFFF, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'h7FFF_FFFF, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'h8000_0000, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'd1, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'd1000000000, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'd0 - 32'd999999999, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'd9, ROW_ZERO, 5'd0);
		// directed: eight-bit bus
		add_bus_mode(BUS_EIGHT);
		add_op(OP_CMD, 8'h55, 32'd0, ROW_ZERO, 5'd0);
		add_op(OP_DATA, 8'hFF, 32'd0, ROW_ZERO, 5'd0);
		add_op(OP_CURSOR, 8'h00, 32'd0, ROW_SECOND, 5'd7);
		add_op(OP_NUMBER, 8'h00, 32'h8000_0000, ROW_ZERO, 5'd0);
		add_op(OP_NUMBER, 8'h00, 32'd0, ROW_ZERO, 5'd0);

		// random, no idling; long sink hold-off while the source keeps offering
		add_bus_mode(BUS_FOUR);
		add_idling(IDLE_NONE, IDLE_NONE);
		add_random_ops(60);
		op_plan.push_back(plan_entry(P_HOLD));
		add_random_ops(40);
		op_plan.push_back(plan_entry(P_DRAIN));
		// source idling
		add_bus_mode(BUS_EIGHT);
		add_idling(IDLE_HEAVY, IDLE_NONE);
		add_random_ops(60);
		// sink stalling
		add_bus_mode(BUS_FOUR);
		add_idling(IDLE_NONE, IDLE_HEAVY);
		add_random_ops(60);
		op_plan.push_back(plan_entry(P_DRAIN));
		// both sides idling lightly
		add_bus_mode(BUS_EIGHT);
		add_idling(IDLE_LIGHT, IDLE_LIGHT);
		add_random_ops(60);
		add_bus_mode(BUS_FOUR);
		add_idling(IDLE_LIGHT, IDLE_LIGHT);
		add_random_ops(45);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the plan to empty and the block to go quiet
		@(posedge clk);
		while (op_plan.size() != 0 || s_tvalid || cfg_valid || quiet_cycles < SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/clws_pkg.sv
hw/rtl/clws_emit.sv
hw/rtl/char_lcd_write_sequencer.sv
test/testbench.sv
